@@ src/bfa_pkg.sv @@
// Shared types, constants and command/status structs of the best-fit block allocator.
package bfa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int OFS_W      = 32;
    localparam int LOG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_ALIGN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_ALIGN = 2'd2;
    // Unmapped index: writes to it are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

    localparam logic [OFS_W-1:0] RST_POOL_BYTES = 32'd1048576;
    localparam logic [LOG_W-1:0] RST_SIZE_ALIGN = 5'd8;
    localparam logic [LOG_W-1:0] RST_ADDR_ALIGN = 5'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef struct packed {
        logic             req_type;
        logic [OFS_W-1:0] req_size;
        logic [LOG_W-1:0] req_align_log2;
        logic [OFS_W-1:0] free_offset;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] block_offset;
    } t_res;

    typedef struct packed {
        logic             used;
        logic [OFS_W-1:0] start;
    } t_entry;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ALLOC = 2'd1,
        WR_FREE  = 2'd2,
        WR_SPLIT = 2'd3
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef enum logic [1:0] {
        RS_ZERO   = 2'd0,
        RS_ASTART = 2'd1,
        RS_OFFSET = 2'd2
    } t_res_src;

    typedef struct packed {
        logic     load;
        t_wr_sel  wr_sel;
        logic     mv_start;
        t_cnt_op  cnt_op;
        logic     set_res;
        t_status  res_status;
        t_res_src res_src;
        logic     res_load;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic scan_done;
        logic found;
        logic split;
        logic full;
        logic prev_free;
        logic next_free;
        logic mv_busy;
        logic out_full;
    } t_sts;

endpackage

@@ src/bfa_ctrl.sv @@
// Controller state machine: sequences scan, decision, table move and result transfer.
module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd
);
    import bfa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CALC  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_FIN   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.wr_sel     = WR_NONE;
        o_cmd.mv_start   = 1'b0;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.set_res    = 1'b0;
        o_cmd.res_status = ST_OK;
        o_cmd.res_src    = RS_ZERO;
        o_cmd.res_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.set_res = 1'b1;
                if (!i_sts.is_free) begin
                    if (!i_sts.found) begin
                        o_cmd.res_status = ST_NO_FIT;
                        n_state          = S_DONE;
                    end else if (i_sts.split && i_sts.full) begin
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.res_src = RS_ASTART;
                        o_cmd.wr_sel  = WR_ALLOC;
                        if (i_sts.split) begin
                            o_cmd.mv_start = 1'b1;
                            n_state        = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    o_cmd.res_src = RS_OFFSET;
                    if (!i_sts.found) begin
                        o_cmd.res_status = ST_NOT_ALLOC;
                        n_state          = S_DONE;
                    end else begin
                        if (!i_sts.prev_free) begin
                            o_cmd.wr_sel = WR_FREE;
                        end
                        if (i_sts.prev_free || i_sts.next_free) begin
                            o_cmd.mv_start = 1'b1;
                            n_state        = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (!i_sts.mv_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.is_free) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.wr_sel = WR_SPLIT;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_full || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/bfa_dpath.sv @@
// Datapath: block table memory, scan pipeline, move engine, config and result registers.
module bfa_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bfa_pkg::t_req                  i_in_data,
    input  bfa_pkg::t_cmd                  i_cmd,
    output bfa_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bfa_pkg::t_res                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfa_pkg::OFS_W-1:0]      i_cfg_data
);
    import bfa_pkg::*;

    // Table memory and read register
    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd;

    // Configuration and table count
    logic [OFS_W-1:0] r_pool_bytes;
    logic [LOG_W-1:0] r_sal;
    logic [LOG_W-1:0] r_aal;
    logic [CNT_W-1:0] r_count;

    // Request
    logic             r_type;
    logic [OFS_W:0]   r_size;
    logic [OFS_W-1:0] r_almask;
    logic [OFS_W-1:0] r_off;

    // Scan pipeline
    logic             r_iss_on;
    logic [CNT_W-1:0] r_iss_idx;
    logic             r_rv;
    logic [CNT_W-1:0] r_ri;
    t_entry           r_pv;
    logic             r_e_v;
    logic             r_e_last;
    logic [IDX_W-1:0] r_e_idx;
    logic             r_e_used;
    logic [OFS_W-1:0] r_e_end;
    logic [OFS_W:0]   r_e_astart;
    logic [OFS_W-1:0] r_e_bsz;
    logic             r_fin;

    // Best fit and lookup results
    logic             r_bfound;
    logic [IDX_W-1:0] r_bidx;
    logic [OFS_W:0]   r_bastart;
    logic [OFS_W-1:0] r_bbsz;
    logic [OFS_W-1:0] r_bend;
    logic [OFS_W+1:0] r_lim;
    logic             r_ffound;
    logic [IDX_W-1:0] r_fidx;
    logic             r_prev_free;
    logic             r_next_free;

    // Move engine
    logic [CNT_W-1:0] r_mv_addr;
    logic [CNT_W-1:0] r_mv_left;
    logic             r_mrv;
    logic [IDX_W-1:0] r_mri;

    // Result and output registers
    t_status          r_rstat;
    logic [OFS_W-1:0] r_roff;
    logic             r_out_v;
    t_res             r_out;

    logic             init;
    logic [OFS_W:0]   sa;
    logic [OFS_W:0]   sa_m1;
    logic [OFS_W:0]   req_rnd;
    logic [LOG_W-1:0] alog;
    logic [OFS_W-1:0] al_m1;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             w_we;
    logic [IDX_W-1:0] w_addr;
    t_entry           w_data;
    logic [1:0]       merge_d;
    logic [CNT_W-1:0] mv_src;
    logic [OFS_W-1:0] e_end_n;
    logic [OFS_W:0]   e_astart_n;
    logic             fit;
    logic             split;

    assign init = !i_rst_n || (i_cfg_we && (i_cfg_index == CFG_POOL_BYTES));

    // Round size up and widen alignment
    assign sa      = (OFS_W+1)'(1) << r_sal;
    assign sa_m1   = sa - (OFS_W+1)'(1);
    assign req_rnd = ({1'b0, i_in_data.req_size} + sa_m1) & ~sa_m1;
    assign alog    = (i_in_data.req_align_log2 > r_aal) ? i_in_data.req_align_log2 : r_aal;
    assign al_m1   = (OFS_W'(1) << alog) - OFS_W'(1);

    assign merge_d = 2'(r_prev_free) + 2'(r_next_free);
    assign mv_src  = CNT_W'(r_fidx) + CNT_W'(1) + CNT_W'(r_next_free);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes <= RST_POOL_BYTES;
            r_sal        <= RST_SIZE_ALIGN;
            r_aal        <= RST_ADDR_ALIGN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POOL_BYTES: r_pool_bytes <= i_cfg_data;
                CFG_SIZE_ALIGN: r_sal        <= i_cfg_data[LOG_W-1:0];
                CFG_ADDR_ALIGN: r_aal        <= i_cfg_data[LOG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Block count
    always_ff @(posedge i_clk) begin
        if (init) begin
            r_count <= CNT_W'(1);
        end else begin
            unique case (i_cmd.cnt_op)
                CNT_INC:  r_count <= r_count + CNT_W'(1);
                CNT_DEC:  r_count <= r_count - CNT_W'(merge_d);
                default:  ;
            endcase
        end
    end

    // Latch request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type   <= i_in_data.req_type;
            r_size   <= req_rnd;
            r_almask <= al_m1;
            r_off    <= i_in_data.free_offset;
        end
    end

    // Memory read port: move engine or scan
    assign rd_en   = (r_mv_left != '0) || r_iss_on;
    assign rd_addr = (r_mv_left != '0) ? r_mv_addr[IDX_W-1:0] : r_iss_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Memory write port: init, move, single entry update
    always_comb begin
        w_we   = 1'b0;
        w_addr = '0;
        w_data = '0;
        priority if (init) begin
            w_we = 1'b1;
        end else if (r_mrv) begin
            w_we   = 1'b1;
            w_addr = (r_type == REQ_FREE) ? (r_mri - IDX_W'(merge_d)) : (r_mri + IDX_W'(1));
            w_data = r_rd;
        end else begin
            unique case (i_cmd.wr_sel)
                WR_ALLOC: begin
                    w_we         = 1'b1;
                    w_addr       = r_bidx;
                    w_data.used  = 1'b1;
                    w_data.start = r_bastart[OFS_W-1:0];
                end
                WR_FREE: begin
                    w_we         = 1'b1;
                    w_addr       = r_fidx;
                    w_data.start = r_off;
                end
                WR_SPLIT: begin
                    w_we         = 1'b1;
                    w_addr       = r_bidx + IDX_W'(1);
                    w_data.start = r_lim[OFS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
    end

    // Scan control: issue entries 0..count, the last slot closes the final block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_on <= 1'b0;
            r_rv     <= 1'b0;
            r_e_v    <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_iss_on <= 1'b1;
            end else if (r_iss_on && (r_iss_idx == r_count)) begin
                r_iss_on <= 1'b0;
            end
            r_rv  <= r_iss_on;
            r_e_v <= r_rv && (r_ri != '0);
            r_fin <= r_e_v && r_e_last;
        end
    end

    // Scan payload: pair previous entry with the next start
    assign e_end_n    = (r_ri == r_count) ? r_pool_bytes : r_rd.start;
    assign e_astart_n = ({1'b0, r_pv.start} + {1'b0, r_almask}) & ~{1'b0, r_almask};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iss_idx <= '0;
        end else if (r_iss_on) begin
            r_iss_idx <= r_iss_idx + CNT_W'(1);
        end
        r_ri <= r_iss_idx;
        if (r_rv) begin
            r_pv       <= r_rd;
            r_e_last   <= (r_ri == r_count);
            r_e_idx    <= IDX_W'(r_ri - CNT_W'(1));
            r_e_used   <= r_pv.used;
            r_e_end    <= e_end_n;
            r_e_astart <= e_astart_n;
            r_e_bsz    <= e_end_n - r_pv.start;
        end
    end

    // Best fit: smallest block that holds the request, first one wins ties
    assign fit = !r_e_used &&
                 (({1'b0, r_e_astart} + {1'b0, r_size}) <= {2'b00, r_e_end});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bfound <= 1'b0;
        end else if (r_e_v && fit && (!r_bfound || (r_e_bsz < r_bbsz))) begin
            r_bfound  <= 1'b1;
            r_bidx    <= r_e_idx;
            r_bastart <= r_e_astart;
            r_bbsz    <= r_e_bsz;
            r_bend    <= r_e_end;
        end
        r_lim <= {1'b0, r_bastart} + {1'b0, r_size};
    end

    assign split = (({2'b00, r_bend} - r_lim) >= {1'b0, sa});

    // Free lookup: lowest used entry at the offset, plus neighbor state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ffound    <= 1'b0;
            r_prev_free <= 1'b0;
            r_next_free <= 1'b0;
        end else if (r_rv && (r_type == REQ_FREE) && (r_ri < r_count)) begin
            if (!r_ffound && r_rd.used && (r_rd.start == r_off)) begin
                r_ffound    <= 1'b1;
                r_fidx      <= r_ri[IDX_W-1:0];
                r_prev_free <= (r_ri != '0) && !r_pv.used;
            end
            if (r_ffound && (r_ri == (CNT_W'(r_fidx) + CNT_W'(1)))) begin
                r_next_free <= !r_rd.used;
            end
        end
    end

    // Move engine: shift entries up for a split, down for a merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_left <= '0;
            r_mrv     <= 1'b0;
        end else begin
            if (i_cmd.mv_start) begin
                if (r_type == REQ_FREE) begin
                    r_mv_left <= r_count - mv_src;
                end else begin
                    r_mv_left <= r_count - CNT_W'(1) - CNT_W'(r_bidx);
                end
            end else if (r_mv_left != '0) begin
                r_mv_left <= r_mv_left - CNT_W'(1);
            end
            r_mrv <= (r_mv_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mv_start) begin
            r_mv_addr <= (r_type == REQ_FREE) ? mv_src : (r_count - CNT_W'(1));
        end else if (r_mv_left != '0) begin
            r_mv_addr <= (r_type == REQ_FREE) ? (r_mv_addr + CNT_W'(1))
                                              : (r_mv_addr - CNT_W'(1));
        end
        r_mri <= r_mv_addr[IDX_W-1:0];
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_rstat <= i_cmd.res_status;
            unique case (i_cmd.res_src)
                RS_ASTART: r_roff <= r_bastart[OFS_W-1:0];
                RS_OFFSET: r_roff <= r_off;
                default:   r_roff <= '0;
            endcase
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out.status       <= r_rstat;
            r_out.block_offset <= r_roff;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign o_sts.is_free   = (r_type == REQ_FREE);
    assign o_sts.scan_done = r_fin;
    assign o_sts.found     = (r_type == REQ_FREE) ? r_ffound : r_bfound;
    assign o_sts.split     = split;
    assign o_sts.full      = (r_count >= CNT_W'(MAX_BLOCKS));
    assign o_sts.prev_free = r_prev_free;
    assign o_sts.next_free = r_next_free;
    assign o_sts.mv_busy   = (r_mv_left != '0) || r_mrv;
    assign o_sts.out_full  = r_out_v;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_port_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rv && r_mrv))
        else $error("scan and move read the table together");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && r_out_v) |-> i_out_ready)
        else $error("result loaded over an untaken result");

    a_move_idle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mv_start |-> (!r_iss_on && !r_rv && (r_mv_left == '0)))
        else $error("move started while table is busy");

endmodule

@@ src/best_fit_block_allocator.sv @@
// Top level of the best-fit block allocator: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_req)
//  out     | output    | o_out_valid/i_out_ready | o_out_data (t_res)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One request at a time. Each request reads count + 1 table entries through the single
// read port, then passes the scan pipeline and the decision.
// A split or merge then shifts the entries behind the block through the move engine.
// Reset and a pool size write leave one free block spanning the memory at once.
// A waiting result sits in the output register; the next request is taken
// while it waits, and its result holds until the first one transfers.
module best_fit_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bfa_pkg::t_req                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bfa_pkg::t_res                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfa_pkg::OFS_W-1:0]     i_cfg_data
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

@@ tb/best_fit_block_allocator_check.sv @@
// Checker for the best-fit block allocator: predicts each result and compares it.
module best_fit_block_allocator_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  bfa_pkg::t_req                 i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  bfa_pkg::t_res                 i_out_data,
    input  logic                          i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfa_pkg::OFS_W-1:0]     i_cfg_data,
    output int                            o_fail_cnt,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bfa_pkg::*;

    // Predicted block table and register copies
    logic [OFS_W-1:0] tbl_start [MAX_BLOCKS];
    bit               tbl_used  [MAX_BLOCKS];
    int               tbl_cnt;
    logic [OFS_W-1:0] mem_bytes;
    logic [LOG_W-1:0] size_log;
    logic [LOG_W-1:0] addr_log;

    t_res expected_results[$];
    int   fails;

    assign o_fail_cnt = fails;
    assign o_pending  = expected_results.size();

    function automatic void clear_table();
        for (int j = 0; j < MAX_BLOCKS; j++) begin
            tbl_start[j] = '0;
            tbl_used[j]  = 1'b0;
        end
        tbl_cnt = 1;
    endfunction

    function automatic void drop_entry(int k);
        if (k >= tbl_cnt || tbl_cnt <= 1) return;
        for (int j = k; j < tbl_cnt - 1; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_used[j]  = tbl_used[j+1];
        end
        tbl_cnt--;
        tbl_start[tbl_cnt] = '0;
        tbl_used[tbl_cnt]  = 1'b0;
    endfunction

    // Best-fit search, alignment, optional split
    function automatic t_res alloc_block(logic [OFS_W-1:0] bytes, logic [LOG_W-1:0] req_log);
        logic [63:0] sa, sz, al, st, fin, bsz, ast, best_sz, best_ast, rem;
        logic [LOG_W-1:0] alog;
        bit   found;
        int   best;
        t_res r;
        sa = 64'd1 << size_log;
        sz = ({32'd0, bytes} + sa - 64'd1) & ~(sa - 64'd1);
        alog = (addr_log > req_log) ? addr_log : req_log;
        al = 64'd1 << alog;
        found = 1'b0;
        best = 0;
        best_sz = '0;
        best_ast = '0;
        r.status = ST_NO_FIT;
        r.block_offset = '0;
        for (int j = 0; j < tbl_cnt; j++) begin
            if (!tbl_used[j]) begin
                st  = {32'd0, tbl_start[j]};
                fin = (j + 1 < tbl_cnt) ? {32'd0, tbl_start[j+1]} : {32'd0, mem_bytes};
                bsz = fin - st;
                ast = (st + al - 64'd1) & ~(al - 64'd1);
                if (sz + (ast - st) <= bsz && (!found || bsz < best_sz)) begin
                    found = 1'b1;
                    best = j;
                    best_sz = bsz;
                    best_ast = ast;
                end
            end
        end
        if (!found) return r;
        rem = best_sz - (best_ast - {32'd0, tbl_start[best]}) - sz;
        if (rem >= sa && tbl_cnt >= MAX_BLOCKS) begin
            r.status = ST_FULL;
            return r;
        end
        tbl_start[best] = best_ast[31:0];
        if (rem >= sa) begin
            for (int j = tbl_cnt; j > best + 1; j--) begin
                tbl_start[j] = tbl_start[j-1];
                tbl_used[j]  = tbl_used[j-1];
            end
            tbl_start[best+1] = best_ast[31:0] + sz[31:0];
            tbl_used[best+1]  = 1'b0;
            tbl_cnt++;
        end
        tbl_used[best] = 1'b1;
        r.status = ST_OK;
        r.block_offset = best_ast[31:0];
        return r;
    endfunction

    // Release by start offset and coalesce with free neighbors
    function automatic t_res release_block(logic [OFS_W-1:0] ofs);
        int   k;
        t_res r;
        k = -1;
        r.block_offset = ofs;
        for (int j = 0; j < tbl_cnt; j++)
            if (k < 0 && tbl_used[j] && tbl_start[j] == ofs) k = j;
        if (k < 0) begin
            r.status = ST_NOT_ALLOC;
            return r;
        end
        tbl_used[k] = 1'b0;
        if (k + 1 < tbl_cnt && !tbl_used[k+1]) drop_entry(k + 1);
        if (k > 0 && !tbl_used[k-1]) drop_entry(k);
        r.status = ST_OK;
        return r;
    endfunction

    // Track config writes, predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            mem_bytes = RST_POOL_BYTES;
            size_log  = RST_SIZE_ALIGN;
            addr_log  = RST_ADDR_ALIGN;
            clear_table();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_BYTES: begin
                        mem_bytes = i_cfg_data;
                        clear_table();
                    end
                    CFG_SIZE_ALIGN: size_log = i_cfg_data[LOG_W-1:0];
                    CFG_ADDR_ALIGN: addr_log = i_cfg_data[LOG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: status %0d offset %h",
                           got.status, got.block_offset);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.block_offset !== want.block_offset) begin
                        $error("block_offset: expected %h actual %h",
                               want.block_offset, got.block_offset);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == REQ_FREE)
                    expected_results.push_back(release_block(i_in_data.free_offset));
                else
                    expected_results.push_back(alloc_block(i_in_data.req_size,
                                                           i_in_data.req_align_log2));
            end
        end
    end

endmodule

@@ tb/best_fit_block_allocator_tb.sv @@
// Stimulus, handshake pacing and verdict for the best-fit block allocator.
module best_fit_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_req                 in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_res                 out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [OFS_W-1:0]     cfg_data = '0;
    int                   fail_cnt;
    int                   pending;

    int                   send_idle;
    int                   recv_idle;
    int                   sent_cnt;
    int                   quiet_cycles;
    bit                   held;
    int                   hold_left;
    logic [OFS_W-1:0]     live_offsets[$];
    logic                 req_kinds[$];

    always #5 i_clk = ~i_clk;

    best_fit_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    best_fit_block_allocator_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    // Receiver pacing, with one long hold-off early in the run
    always @(negedge i_clk) begin
        if (!held && sent_cnt == 100) begin
            held = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Keep live allocations for frees; watchdog on transfers
    always @(posedge i_clk) begin
        logic kind;
        if (i_rst_n) begin
            if (in_valid && in_ready) req_kinds.push_back(in_data.req_type);
            if (out_valid && out_ready && req_kinds.size() > 0) begin
                kind = req_kinds.pop_front();
                if (kind == REQ_ALLOC && out_data.status == ST_OK)
                    live_offsets.push_back(out_data.block_offset);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_req(t_req r);
        while ($urandom_range(0, 99) < send_idle) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (!in_ready);
        sent_cnt++;
    endtask

    task automatic send_alloc(logic [OFS_W-1:0] bytes, logic [LOG_W-1:0] alog);
        t_req r;
        r.req_type = REQ_ALLOC;
        r.req_size = bytes;
        r.req_align_log2 = alog;
        r.free_offset = $urandom();
        send_req(r);
    endtask

    task automatic send_free(logic [OFS_W-1:0] ofs);
        t_req r;
        r.req_type = REQ_FREE;
        r.req_size = $urandom();
        r.req_align_log2 = $urandom_range(0, 31);
        r.free_offset = ofs;
        send_req(r);
    endtask

    // Drop valid and pause until every result is back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_POOL_BYTES) live_offsets.delete();
    endtask

    // Mostly well-formed alloc/free traffic, with some noise
    task automatic random_traffic(int n);
        int pick, idx;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 9) == 0)
                    send_alloc($urandom(), $urandom_range(0, 31));
                else
                    send_alloc($urandom_range(0, 4096), $urandom_range(0, 12));
            end else if (pick < 90 && live_offsets.size() > 0) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                send_free(live_offsets[idx]);
                live_offsets.delete(idx);
            end else begin
                send_free($urandom());
            end
        end
    endtask

    initial begin
        sent_cnt = 0;
        quiet_cycles = 0;
        held = 1'b0;
        hold_left = 0;
        send_idle = 36;
        recv_idle = 69;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, no fit, exact fit, unknown frees
        send_alloc(32'd0, 5'd0);
        send_alloc(32'hFFFF_FFFF, 5'd0);
        send_alloc(32'd1, 5'd31);
        send_alloc(32'd1, 5'd0);
        send_alloc(32'd300, 5'd10);
        send_free(32'hFFFF_FFFF);
        send_free(32'd0);
        drain();
        while (live_offsets.size() > 0) send_free(live_offsets.pop_front());
        send_alloc(32'd1048576, 5'd0);
        send_alloc(32'd1, 5'd3);
        drain();
        while (live_offsets.size() > 0) send_free(live_offsets.pop_front());
        random_traffic(230);
        drain();

        // Fine granularity, small memory: fill the table up
        send_idle = 69;
        recv_idle = 36;
        write_reg(CFG_SIZE_ALIGN, 32'd0);
        write_reg(CFG_ADDR_ALIGN, 32'd0);
        write_reg(CFG_POOL_BYTES, 32'd5000);
        for (int i = 0; i < 70; i++) send_alloc(32'd1, 5'd0);
        send_alloc(32'd0, 5'd0);
        drain();
        random_traffic(200);
        drain();

        // Widest extremes
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_POOL_BYTES, 32'hFFFF_FFFF);
        write_reg(CFG_SIZE_ALIGN, 32'd31);
        write_reg(CFG_ADDR_ALIGN, 32'hFFFF_FFFF);
        send_alloc(32'h8000_0000, 5'd31);
        send_alloc(32'd1, 5'd0);
        random_traffic(40);
        drain();
        write_reg(CFG_POOL_BYTES, 32'd0);
        write_reg(CFG_SIZE_ALIGN, 32'd4);
        write_reg(CFG_ADDR_ALIGN, 32'd2);
        write_reg(CFG_SPARE, 32'hA5A5_A5A5);
        send_alloc(32'd0, 5'd0);
        random_traffic(20);
        drain();

        // Back to the reset setting, no idling
        write_reg(CFG_POOL_BYTES, 32'd1048576);
        write_reg(CFG_SIZE_ALIGN, 32'd8);
        write_reg(CFG_ADDR_ALIGN, 32'd3);
        random_traffic(200);
        drain();

        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
